// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the convolver RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pcv assertion failed");
`define PCV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pcv assertion failed");
`else
`define PCV_ASSERT(lbl, clk, rstn, prop)
`define PCV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/pcv_pkg.sv =====
// Shared types, codes and constants of the preamp response convolver.
// No dependencies.
package pcv_pkg;

  localparam int MAX_TAPS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 16;

  localparam int COEF_ADDR_W = 8;
  localparam int TAP_CFG_W   = 9;
  localparam int GAIN_W      = 16;
  localparam int LEAD_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int AMP_W       = 48;

  localparam int ACC_W       = 57;
  localparam int ACC_SPLIT   = 29;
  localparam int SCALE_SHIFT = 8;
  localparam int SCL_W       = ACC_W + GAIN_W;

  localparam logic [ACC_W-1:0]     ACC_CAP   = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [TAP_CFG_W-1:0] TAP_RESET = 9'd256;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd256;
  localparam logic [LEAD_W-1:0]    LEAD_RESET = 8'd0;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT = 2'd0,
    CFG_GAIN      = 2'd1,
    CFG_LEAD_BINS = 2'd2
  } pcv_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DONE
  } pcv_state_t;

  typedef struct packed {
    logic clr;
    logic issue;
    logic zero;
    logic mul_lo;
    logic mul_hi;
    logic sum;
  } pcv_mac_ctl_t;

  typedef struct packed {
    logic busy;
  } pcv_mac_sts_t;

endpackage

// ===== hdl/pcv_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module pcv_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pcv_mac.sv =====
// Multiply-accumulate and gain scaling datapath of the convolver.
// Depends on pcv_pkg for the control struct and accumulator constants.
module pcv_mac #(
  parameter int COUNT_BITS = pcv_pkg::COUNT_BITS_DEF,
  parameter int COEF_BITS  = pcv_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcv_pkg::pcv_mac_ctl_t       ctl,
  input  logic [COEF_BITS-1:0]        kern_q,
  input  logic [COUNT_BITS-1:0]       hist_q,
  input  logic [pcv_pkg::GAIN_W-1:0]  gain,
  output pcv_pkg::pcv_mac_sts_t       sts,
  output logic [pcv_pkg::AMP_W-1:0]   amplitude
);
  import pcv_pkg::*;

  localparam int PW    = COEF_BITS + COUNT_BITS;
  localparam int LO_W  = ACC_SPLIT + GAIN_W;
  localparam int HI_W  = ACC_W - ACC_SPLIT + GAIN_W;

  logic             rd_vld_r;
  logic             rd_zero_r;
  logic             prod_vld_r;
  logic [PW-1:0]    prod_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_sum;
  logic [LO_W-1:0]  plo_r;
  logic [HI_W-1:0]  phi_r;
  logic [SCL_W-1:0] scl;
  logic [AMP_W-1:0] amp_r;

  assign acc_sum = acc_r + ACC_W'(prod_r);
  assign scl     = SCL_W'(plo_r) + (SCL_W'(phi_r) << ACC_SPLIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= ctl.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_zero_r <= ctl.zero;
    prod_r    <= rd_zero_r ? '0 : PW'(kern_q) * PW'(hist_q);
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= (acc_sum >= ACC_CAP) ? ACC_CAP : acc_sum;
    end
    if (ctl.mul_lo) begin
      plo_r <= LO_W'(acc_r[ACC_SPLIT-1:0]) * LO_W'(gain);
    end
    if (ctl.mul_hi) begin
      phi_r <= HI_W'(acc_r[ACC_W-1:ACC_SPLIT]) * HI_W'(gain);
    end
    if (ctl.sum) begin
      amp_r <= (|scl[SCL_W-1:AMP_W+SCALE_SHIFT]) ? '1 :
               scl[AMP_W+SCALE_SHIFT-1:SCALE_SHIFT];
    end
  end

  assign sts.busy  = rd_vld_r | prod_vld_r;
  assign amplitude = amp_r;

endmodule

// ===== hdl/preamp_response_convolver_core.sv =====
// Top level of the preamp response convolver: control sequencer and memories.
// Depends on pcv_pkg, pcv_ram, pcv_mac and assert_macros.svh.
//
// Input channel (in_valid / in_stall): one beat is a command. A load beat
// (command 0) writes one kernel coefficient and gives no result.
// A sample beat (command 1) writes the count into the circular history and,
// unless suppressed, runs one tap per cycle over the kernel and history RAMs.
// A sample then passes the states read (skipped with tap count 0), drain,
// mul_lo, mul_hi, sum and done on its way to the result register; the next
// beat is taken once the sequencer is back in idle. Suppressed samples and
// loads leave the sequencer in idle. Result beats leave on out_valid /
// out_stall from an output register; a new beat is taken while a result
// still waits, and the sequencer holds a finished result only while that
// register is full and stalled. Configuration (cfg_valid / cfg_ready) is
// always ready. Reset clears the history (by fill count), the suppress
// counter, the registers to tap_count 256, gain 1.0, lead_bins 0; the kernel
// RAM is not cleared and needs loading before use. No clearing pass is run.
`include "assert_macros.svh"
module preamp_response_convolver_core #(
  parameter int MAX_TAPS   = pcv_pkg::MAX_TAPS_DEF,
  parameter int COUNT_BITS = pcv_pkg::COUNT_BITS_DEF,
  parameter int COEF_BITS  = pcv_pkg::COEF_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [pcv_pkg::COEF_ADDR_W-1:0] in_coef_address,
  input  logic [COEF_BITS-1:0]           in_coef_value,
  input  logic [COUNT_BITS-1:0]          in_electron_count,
  input  logic                           in_first_bin,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pcv_pkg::AMP_W-1:0]      out_amplitude,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcv_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  pcv_state_t           state_r, state_nxt;
  logic [TAP_CFG_W-1:0] tap_count_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [LEAD_W-1:0]    lead_r;
  logic [LEAD_W-1:0]    suppress_r;
  logic [CW-1:0]        fill_r;
  logic [CW-1:0]        taps_r;
  logic [CW-1:0]        k_r;
  logic [AW-1:0]        wptr_r;
  logic [AW-1:0]        rptr_r;
  logic                 out_valid_r;
  logic [AMP_W-1:0]     out_amp_r;

  logic                 in_acc;
  logic                 smp_acc;
  logic                 kern_we;
  logic [LEAD_W-1:0]    sup_sel;
  logic [CW-1:0]        taps_eff;
  logic [31:0]          addr_ext;
  logic                 k_last;
  logic                 out_free;
  pcv_mac_ctl_t         mac_ctl;
  pcv_mac_sts_t         mac_sts;
  logic [COEF_BITS-1:0] kern_q;
  logic [COUNT_BITS-1:0] hist_q;
  logic [AMP_W-1:0]     mac_amp;

  assign in_acc   = in_valid && !in_stall;
  assign smp_acc  = in_acc && (in_command == CMD_SAMPLE);
  assign addr_ext = 32'(in_coef_address);
  assign kern_we  = in_acc && (in_command == CMD_LOAD) && (addr_ext < 32'(MAX_TAPS));
  assign sup_sel  = in_first_bin ? lead_r : suppress_r;
  assign taps_eff = (32'(tap_count_r) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count_r);
  assign k_last   = (CW'(k_r + 1'b1) == taps_r);
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_amplitude = out_amp_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (smp_acc && (sup_sel == '0)) begin
          state_nxt = (taps_eff == '0) ? ST_DRAIN : ST_READ;
        end
      end
      ST_READ: begin
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_sts.busy) begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    mac_ctl.clr    = smp_acc;
    mac_ctl.issue  = (state_r == ST_READ);
    mac_ctl.zero   = (k_r >= fill_r);
    mac_ctl.mul_lo = (state_r == ST_MUL_LO);
    mac_ctl.mul_hi = (state_r == ST_MUL_HI);
    mac_ctl.sum    = (state_r == ST_SUM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_RESET;
      gain_r      <= GAIN_RESET;
      lead_r      <= LEAD_RESET;
      suppress_r  <= '0;
      fill_r      <= '0;
      wptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TAP_COUNT: tap_count_r <= cfg_data[TAP_CFG_W-1:0];
          CFG_GAIN:      gain_r      <= cfg_data[GAIN_W-1:0];
          CFG_LEAD_BINS: lead_r      <= cfg_data[LEAD_W-1:0];
          default:       ;
        endcase
      end
      if (smp_acc) begin
        wptr_r     <= (wptr_r == AW'(MAX_TAPS - 1)) ? '0 : AW'(wptr_r + 1'b1);
        fill_r     <= in_first_bin ? CW'(1) :
                      ((fill_r == CW'(MAX_TAPS)) ? fill_r : CW'(fill_r + 1'b1));
        suppress_r <= (sup_sel != '0) ? LEAD_W'(sup_sel - 1'b1) : '0;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      taps_r <= taps_eff;
      k_r    <= '0;
      rptr_r <= wptr_r;
    end else if (state_r == ST_READ) begin
      k_r    <= CW'(k_r + 1'b1);
      rptr_r <= (rptr_r == '0) ? AW'(MAX_TAPS - 1) : AW'(rptr_r - 1'b1);
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_amp_r <= mac_amp;
    end
  end

  pcv_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_TAPS),
    .ADDR_W(AW)
  ) u_kern_ram (
    .clk  (clk),
    .we   (kern_we),
    .waddr(addr_ext[AW-1:0]),
    .wdata(in_coef_value),
    .re   (mac_ctl.issue),
    .raddr(k_r[AW-1:0]),
    .rdata(kern_q)
  );

  pcv_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_TAPS),
    .ADDR_W(AW)
  ) u_hist_ram (
    .clk  (clk),
    .we   (smp_acc),
    .waddr(wptr_r),
    .wdata(in_electron_count),
    .re   (mac_ctl.issue),
    .raddr(rptr_r),
    .rdata(hist_q)
  );

  pcv_mac #(
    .COUNT_BITS(COUNT_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .kern_q   (kern_q),
    .hist_q   (hist_q),
    .gain     (gain_r),
    .sts      (mac_sts),
    .amplitude(mac_amp)
  );

  `PCV_ASSERT(a_read_in_range, clk, rst_n, (state_r == ST_READ) |-> (k_r < taps_r))
  `PCV_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CW'(MAX_TAPS))
  `PCV_ASSERT(a_first_bin_fill, clk, rst_n, (smp_acc && in_first_bin) |=> (fill_r == CW'(1)))
  `PCV_ASSERT(a_no_rw_overlap, clk, rst_n, !((kern_we || smp_acc) && mac_ctl.issue))
  `PCV_ASSERT(a_scale_after_drain, clk, rst_n, (state_r == ST_MUL_LO) |-> !mac_sts.busy)

endmodule

// ===== sim/tb_preamp_response_convolver_core.sv =====
// Self-checking testbench for preamp_response_convolver_core: kernel loads,
// count samples and register writes, checked beat by beat against a local predictor.
// Depends on pcv_pkg and the convolver RTL only.
`timescale 1ns / 100ps

module tb_preamp_response_convolver_core;
  import pcv_pkg::*;

  localparam int          TAPS        = MAX_TAPS_DEF;
  localparam int          ITEM_TARGET = 1800;
  localparam int          TAIL_CYCLES = TAPS + 16;
  localparam int          DRAIN_LIMIT = 50000;
  localparam int unsigned CYCLE_LIMIT = 2500000;
  localparam int          DIR_ROWS    = 26;
  localparam int          MAX_REPORTS = 10;

  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 2'd3;
  localparam logic [AMP_W-1:0]     AMP_FULL   = '1;
  localparam logic [63:0]          ACC_LIMIT  = 64'd1 << 56;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_data;
    logic [COEF_ADDR_W-1:0]    addr;
    logic [COEF_BITS_DEF-1:0]  coef;
    logic [COUNT_BITS_DEF-1:0] count;
    logic                      first;
    logic                      typed;
    logic [AMP_W-1:0]          amp;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_command = CMD_LOAD;
  logic [COEF_ADDR_W-1:0]    in_coef_address = '0;
  logic [COEF_BITS_DEF-1:0]  in_coef_value = '0;
  logic [COUNT_BITS_DEF-1:0] in_electron_count = '0;
  logic                      in_first_bin = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [AMP_W-1:0]          out_amplitude;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  logic [COUNT_BITS_DEF-1:0] bins_mem [TAPS];
  logic [COEF_BITS_DEF-1:0]  coef_mem [TAPS];
  logic [LEAD_W-1:0]         hold_count;
  logic [TAP_CFG_W-1:0]      taps_reg;
  logic [GAIN_W-1:0]         gain_reg;
  logic [LEAD_W-1:0]         lead_reg;

  logic [AMP_W-1:0] pending_amplitudes [$];
  logic [AMP_W-1:0] want_amp;
  int               error_count = 0;
  int               items_sent = 0;
  int               burst_left = 0;
  int               stall_mode = 0;
  int               stall_span = 0;
  int unsigned      cycle_count = 0;

  preamp_response_convolver_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_coef_address   (in_coef_address),
    .in_coef_value     (in_coef_value),
    .in_electron_count (in_electron_count),
    .in_first_bin      (in_first_bin),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_amplitude     (out_amplitude),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(32, 400);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom % 4 == 0);
      2: out_stall <= ($urandom % 4 != 0);
      default: out_stall <= stall_span[2];
    endcase
  end

  task automatic flag_error(input bit orphan, input logic [AMP_W-1:0] want,
                            input logic [AMP_W-1:0] got);
    if (error_count < MAX_REPORTS) begin
      if (orphan)
        $display("amplitude beat with none expected: got %h", got);
      else
        $display("amplitude mismatch: expected %h got %h", want, got);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_amplitudes.size() == 0) begin
        flag_error(1'b1, '0, out_amplitude);
      end else begin
        want_amp = pending_amplitudes.pop_front();
        if (out_amplitude !== want_amp)
          flag_error(1'b0, want_amp, out_amplitude);
      end
    end
  end

  task automatic convolve_bin(input logic cmd, input logic [COEF_ADDR_W-1:0] addr,
                              input logic [COEF_BITS_DEF-1:0] coef,
                              input logic [COUNT_BITS_DEF-1:0] cnt, input logic first,
                              output bit emits, output logic [AMP_W-1:0] amp);
    logic [63:0] acc;
    logic [79:0] scaled;
    int          taps;
    emits = 1'b0;
    amp = '0;
    if (cmd == CMD_LOAD) begin
      coef_mem[addr] = coef;
    end else begin
      if (first) begin
        for (int k = 0; k < TAPS; k++) bins_mem[k] = '0;
        hold_count = lead_reg;
      end
      for (int k = TAPS - 1; k > 0; k--) bins_mem[k] = bins_mem[k - 1];
      bins_mem[0] = cnt;
      if (hold_count != 0) begin
        hold_count--;
      end else begin
        taps = (taps_reg > TAPS) ? TAPS : taps_reg;
        acc = '0;
        for (int k = 0; k < taps; k++) begin
          acc = acc + coef_mem[k] * bins_mem[k];
          if (acc >= ACC_LIMIT) acc = ACC_LIMIT;
        end
        scaled = (acc * gain_reg) >> SCALE_SHIFT;
        amp = (scaled > AMP_FULL) ? AMP_FULL : scaled[AMP_W-1:0];
        emits = 1'b1;
      end
    end
  endtask

  task automatic send_beat(input logic cmd, input logic [COEF_ADDR_W-1:0] addr,
                           input logic [COEF_BITS_DEF-1:0] coef,
                           input logic [COUNT_BITS_DEF-1:0] cnt, input logic first,
                           input bit typed, input logic [AMP_W-1:0] typed_amp);
    int               gap;
    bit               emits;
    logic [AMP_W-1:0] amp;
    if (burst_left == 0) begin
      gap = ($urandom % 8 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom % 4 == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end
    burst_left--;
    in_command        <= cmd;
    in_coef_address   <= addr;
    in_coef_value     <= coef;
    in_electron_count <= cnt;
    in_first_bin      <= first;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    convolve_bin(cmd, addr, coef, cnt, first, emits, amp);
    if (emits)
      pending_amplitudes.push_back(typed ? typed_amp : amp);
  endtask

  // Hold off until every result is out and the datapath has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_amplitudes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_TAP_COUNT: taps_reg = data[TAP_CFG_W-1:0];
      CFG_GAIN:      gain_reg = data[GAIN_W-1:0];
      CFG_LEAD_BINS: lead_reg = data[LEAD_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom % 8)
      0: rand_word = 16'h0000;
      1: rand_word = 16'hFFFF;
      2: rand_word = 16'($urandom_range(0, 15));
      default: rand_word = 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    mk_cfg = '0;
    mk_cfg.kind = ROW_CFG;
    mk_cfg.reg_idx = idx;
    mk_cfg.reg_data = data;
  endfunction

  function automatic stim_row_t mk_beat(input row_kind_t kind, input logic [7:0] addr,
                                        input logic [15:0] coef, input logic [15:0] cnt,
                                        input logic first, input logic typed,
                                        input logic [AMP_W-1:0] amp);
    mk_beat = '0;
    mk_beat.kind = kind;
    mk_beat.addr = addr;
    mk_beat.coef = coef;
    mk_beat.count = cnt;
    mk_beat.first = first;
    mk_beat.typed = typed;
    mk_beat.amp = amp;
  endfunction

  function automatic stim_row_t directed_row(input int i);
    case (i)
      0:  directed_row = mk_cfg(CFG_TAP_COUNT, 16'hFE03);
      1:  directed_row = mk_cfg(UNUSED_REG, 16'hFFFF);
      2:  directed_row = mk_beat(ROW_LOAD, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0);
      3:  directed_row = mk_beat(ROW_LOAD, 8'd1, 16'h0001, 16'h0000, 1'b0, 1'b0, '0);
      4:  directed_row = mk_beat(ROW_LOAD, 8'd2, 16'h8000, 16'h1234, 1'b0, 1'b0, '0);
      5:  directed_row = mk_beat(ROW_LOAD, 8'd255, 16'h0000, 16'h0000, 1'b1, 1'b0, '0);
      6:  directed_row = mk_beat(ROW_SAMPLE, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, '0);
      7:  directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 1'b1,
                                 48'h0000_FFFE_0001);
      8:  directed_row = mk_beat(ROW_SAMPLE, 8'h5A, 16'hA5A5, 16'h0001, 1'b0, 1'b0, '0);
      9:  directed_row = mk_beat(ROW_SAMPLE, 8'hA5, 16'h5A5A, 16'h8000, 1'b0, 1'b0, '0);
      10: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'h1234, 1'b0, 1'b0, '0);
      11: directed_row = mk_cfg(CFG_GAIN, 16'h0000);
      12: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 1'b1, '0);
      13: directed_row = mk_cfg(CFG_GAIN, 16'hFFFF);
      14: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 1'b0, '0);
      15: directed_row = mk_cfg(CFG_TAP_COUNT, 16'h0000);
      16: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 1'b1, '0);
      17: directed_row = mk_cfg(CFG_TAP_COUNT, 16'h0003);
      18: directed_row = mk_cfg(CFG_LEAD_BINS, 16'hFF02);
      19: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'd7, 1'b1, 1'b0, '0);
      20: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'd9, 1'b0, 1'b0, '0);
      21: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'd11, 1'b0, 1'b0, '0);
      22: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 1'b0, '0);
      23: directed_row = mk_beat(ROW_LOAD, 8'd1, 16'hFFFF, 16'h0000, 1'b0, 1'b0, '0);
      24: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'd2, 1'b0, 1'b0, '0);
      default: directed_row = mk_beat(ROW_SAMPLE, 8'h00, 16'h0000, 16'd3, 1'b0, 1'b0, '0);
    endcase
  endfunction

  task automatic run_phase(input int p);
    logic [CFG_DATA_W-1:0] tap_data;
    logic [CFG_DATA_W-1:0] gain_data;
    logic [CFG_DATA_W-1:0] lead_data;
    logic [TAP_CFG_W-1:0]  taps;
    logic [LEAD_W-1:0]     lead;
    int                    quota;
    int                    done_here;
    int                    wave_len;
    settle();
    case ($urandom % 10)
      0:       taps = 9'd0;
      1:       taps = 9'($urandom_range(17, 255));
      2:       taps = 9'($urandom_range(256, 511));
      default: taps = 9'($urandom_range(1, 16));
    endcase
    case ($urandom % 6)
      0:       gain_data = 16'h0000;
      1:       gain_data = 16'hFFFF;
      2:       gain_data = 16'h0100;
      default: gain_data = 16'($urandom);
    endcase
    case ($urandom % 8)
      0:       lead = 8'hFF;
      1, 2:    lead = 8'($urandom_range(1, 6));
      default: lead = 8'h00;
    endcase
    case (p)
      0: begin
        taps = 9'd256;
        gain_data = 16'h0100;
        lead = 8'h00;
      end
      1: begin
        taps = 9'h1FF;
        gain_data = 16'hFFFF;
        lead = 8'h00;
      end
      2: begin
        taps = 9'd4;
        lead = 8'hFF;
      end
      default: ;
    endcase
    tap_data = {7'($urandom), taps};
    lead_data = {8'($urandom), lead};
    write_reg(CFG_TAP_COUNT, tap_data);
    write_reg(CFG_GAIN, gain_data);
    write_reg(CFG_LEAD_BINS, lead_data);
    if ($urandom % 4 == 0)
      write_reg(UNUSED_REG, 16'($urandom));
    cfg_valid <= 1'b0;
    quota = (taps > 32) ? 24 : 110;
    done_here = 0;
    while (done_here < quota) begin
      if ($urandom % 8 != 0) begin
        wave_len = int'(lead) + int'($urandom_range(1, 40));
        for (int b = 0; b < wave_len; b++) begin
          if ($urandom % 10 == 0) begin
            send_beat(CMD_LOAD, 8'($urandom), rand_word(), 16'($urandom), 1'($urandom),
                      1'b0, '0);
            done_here++;
          end
          send_beat(CMD_SAMPLE, 8'($urandom), 16'($urandom), rand_word(), (b == 0),
                    1'b0, '0);
          done_here++;
        end
      end else begin
        send_beat(1'($urandom), 8'($urandom), rand_word(), rand_word(), 1'($urandom),
                  1'b0, '0);
        done_here++;
      end
    end
  endtask

  initial begin
    stim_row_t row;
    stim_row_t prv;
    stim_row_t nxt;
    int        phase;
    int        waited;
    for (int k = 0; k < TAPS; k++) begin
      bins_mem[k] = '0;
      coef_mem[k] = '0;
    end
    hold_count = '0;
    taps_reg = TAP_RESET;
    gain_reg = GAIN_RESET;
    lead_reg = LEAD_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_row(i);
      if (row.kind == ROW_CFG) begin
        if (i > 0)
          prv = directed_row(i - 1);
        if (i == 0 || prv.kind != ROW_CFG)
          settle();
        write_reg(row.reg_idx, row.reg_data);
        nxt = directed_row(i + 1);
        if (i == DIR_ROWS - 1 || nxt.kind != ROW_CFG)
          cfg_valid <= 1'b0;
      end else begin
        send_beat((row.kind == ROW_LOAD) ? CMD_LOAD : CMD_SAMPLE, row.addr, row.coef,
                  row.count, row.first, row.typed, row.amp);
      end
    end

    // Fill the whole kernel so any tap count reads written coefficients only.
    for (int a = 0; a < TAPS; a++)
      send_beat(CMD_LOAD, 8'(a), rand_word(), 16'($urandom), 1'($urandom), 1'b0, '0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_amplitudes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_amplitudes.size() != 0) begin
      $display("%0d amplitude beats never arrived", pending_amplitudes.size());
      error_count++;
    end
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pcv_pkg.sv
hdl/pcv_ram.sv
hdl/pcv_mac.sv
hdl/preamp_response_convolver_core.sv
sim/tb_preamp_response_convolver_core.sv
